// ----- rtl/cks_pkg.sv -----
// Shared types and constants for the command-keyed XOR scrambler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cks_pkg;

	localparam int TEXT_DEPTH = 1024;
	localparam int IDX_W      = $clog2(TEXT_DEPTH);
	localparam int ADDR_W     = 10;
	localparam int BYTE_W     = 8;
	localparam int ACT_W      = 2;

	localparam logic [ACT_W-1:0] ACT_LOAD     = 2'd0;
	localparam logic [ACT_W-1:0] ACT_START    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SCRAMBLE = 2'd2;

	localparam logic [BYTE_W-1:0] CHAR_DOT     = 8'h2E;
	localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
	localparam logic [BYTE_W-1:0] CHAR_MAX     = 8'd127;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [BYTE_W-1:0] data;
	} text_wr_t;

	typedef struct packed {
		logic [BYTE_W-1:0] cur;
		logic [BYTE_W-1:0] first;
	} text_rd_t;

endpackage

`default_nettype wire

// ----- rtl/cks_text_store.sv -----
// Command string store with a prefetched read of the current entry.
// Depends on cks_pkg for widths and the read and write structs.
`timescale 1ns / 1ps
`default_nettype none

module cks_text_store (
	input  wire                     clk,
	input  wire                     arst_n,
	input  cks_pkg::text_wr_t       wr,
	input  wire [cks_pkg::IDX_W-1:0] rd_addr,
	output cks_pkg::text_rd_t       rd
);
	import cks_pkg::*;

	logic [BYTE_W-1:0] mem [TEXT_DEPTH];
	logic [BYTE_W-1:0] rdata_q;
	logic [BYTE_W-1:0] byp_q;
	logic [BYTE_W-1:0] first_q;
	logic              hit_q;

	// The read port fetches the entry the index will point at after this edge.
	// A write to that same entry in the same cycle is forwarded past the memory.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_q <= mem[rd_addr];
		byp_q   <= wr.data;
		if (wr.en && (wr.addr == '0)) begin
			first_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= wr.en && (wr.addr == rd_addr);
		end
	end

	assign rd.cur   = hit_q ? byp_q : rdata_q;
	assign rd.first = first_q;

endmodule

`default_nettype wire

// ----- rtl/cks_key_unit.sv -----
// Key, string index and position parity, with the per-byte key step.
// Depends on cks_pkg for action codes, character constants and text_rd_t.
`timescale 1ns / 1ps
`default_nettype none

module cks_key_unit (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        accept,
	input  wire [cks_pkg::ACT_W-1:0]   action,
	input  wire [cks_pkg::BYTE_W-1:0]  byte_value,
	input  wire [cks_pkg::BYTE_W-1:0]  message_seed,
	input  wire                        start_odd,
	input  wire [cks_pkg::BYTE_W-1:0]  challenge,
	input  cks_pkg::text_rd_t          rd,
	output logic [cks_pkg::IDX_W-1:0]  idx_next,
	output logic                       res_valid,
	output logic [cks_pkg::BYTE_W-1:0] res_data
);
	import cks_pkg::*;

	logic [BYTE_W-1:0] key_q;
	logic [IDX_W-1:0]  idx_q;
	logic              odd_q;

	logic [BYTE_W-1:0] key_d;
	logic              odd_d;
	logic [IDX_W-1:0]  idx_use;
	logic [IDX_W-1:0]  idx_inc;
	logic [BYTE_W-1:0] ch;
	logic [BYTE_W-1:0] ch_clean;
	logic [BYTE_W-1:0] ch_shift;
	logic [BYTE_W-1:0] key_step;

	// A zero byte is the terminator: the walk restarts at the head of the string.
	assign idx_use  = (rd.cur == '0) ? '0 : idx_q;
	assign ch       = (rd.cur == '0) ? rd.first : rd.cur;
	assign ch_clean = ((ch > CHAR_MAX) || (ch == CHAR_PERCENT)) ? CHAR_DOT : ch;
	assign ch_shift = odd_q ? {ch_clean[BYTE_W-2:0], 1'b0} : ch_clean;
	assign key_step = key_q ^ ch_shift;
	assign idx_inc  = (idx_use == IDX_W'(TEXT_DEPTH - 1)) ? '0 : idx_use + 1'b1;

	always_comb begin
		key_d     = key_q;
		idx_next  = idx_q;
		odd_d     = odd_q;
		res_valid = 1'b0;
		res_data  = byte_value ^ key_step;
		if (accept) begin
			unique case (action)
				ACT_START: begin
					key_d    = challenge ^ message_seed;
					idx_next = '0;
					odd_d    = start_odd;
				end
				ACT_SCRAMBLE: begin
					key_d     = key_step;
					idx_next  = idx_inc;
					odd_d     = ~odd_q;
					res_valid = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			idx_q <= '0;
			odd_q <= 1'b0;
		end else begin
			key_q <= key_d;
			idx_q <= idx_next;
			odd_q <= odd_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/command_keyed_xor_scrambler_core.sv -----
// A scrambled byte appears on data_out in the cycle after its beat is accepted.
// Throughput: one beat per cycle unless out_ready stalls a result; the next byte's
// string read is prefetched from the store's single read port as this one is scrambled.
// Reset clears the key, string index, parity, challenge and the output valid flag.
// The string store is not cleared; entries are undefined until loaded.
// Top level of the scrambler; depends on cks_pkg, cks_text_store and cks_key_unit.
`timescale 1ns / 1ps
`default_nettype none

module command_keyed_xor_scrambler_core (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_wr_en,
	input  wire  [cks_pkg::BYTE_W-1:0]  cfg_wr_data,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire  [cks_pkg::ACT_W-1:0]   action,
	input  wire  [cks_pkg::BYTE_W-1:0]  byte_value,
	input  wire  [cks_pkg::ADDR_W-1:0]  string_addr,
	input  wire  [cks_pkg::BYTE_W-1:0]  message_seed,
	input  wire                         start_odd,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [cks_pkg::BYTE_W-1:0]  data_out
);
	import cks_pkg::*;

	logic [BYTE_W-1:0] challenge_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] data_out_q;

	logic              accept;
	logic              addr_ok;
	text_wr_t          wr;
	text_rd_t          rd;
	logic [IDX_W-1:0]  idx_next;
	logic              res_valid;
	logic [BYTE_W-1:0] res_data;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign addr_ok  = 32'(string_addr) < 32'(TEXT_DEPTH);

	assign wr.en   = accept && (action == ACT_LOAD) && addr_ok;
	assign wr.addr = IDX_W'(string_addr);
	assign wr.data = byte_value;

	cks_text_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_addr (idx_next),
		.rd      (rd)
	);

	cks_key_unit u_key (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.action       (action),
		.byte_value   (byte_value),
		.message_seed (message_seed),
		.start_odd    (start_odd),
		.challenge    (challenge_q),
		.rd           (rd),
		.idx_next     (idx_next),
		.res_valid    (res_valid),
		.res_data     (res_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			challenge_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				challenge_q <= cfg_wr_data;
			end
			if (in_ready) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			data_out_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;

endmodule

`default_nettype wire

// ----- rtl/cks_checker.sv -----
// Port-level checks for the scrambler top level, and the bind that attaches them.
// Depends on cks_pkg for the action codes and on command_keyed_xor_scrambler_core.
`timescale 1ns / 1ps
`default_nettype none

module cks_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_valid,
	input wire                        in_ready,
	input wire [cks_pkg::ACT_W-1:0]   action,
	input wire                        out_valid,
	input wire                        out_ready,
	input wire [cks_pkg::BYTE_W-1:0]  data_out
);
	import cks_pkg::*;

	// A stalled result beat keeps its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out))
		else $error("result beat changed while stalled");

	// Every accepted scramble beat produces a result in the next cycle.
	a_scramble_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == ACT_SCRAMBLE) |=> out_valid)
		else $error("scramble beat gave no result");

	// Loads, starts and unused actions never produce a result.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action != ACT_SCRAMBLE) |=> !out_valid)
		else $error("result appeared for a non-scramble beat");

	// A cycle spent in reset leaves no result pending.
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid after reset");

endmodule

bind command_keyed_xor_scrambler_core cks_checker u_cks_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.action    (action),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.data_out  (data_out)
);

`default_nettype wire
